// ----- rtl/core/tcce_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tcce_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CUR_W      = 12;
  localparam int SCR_W      = 13;
  localparam int CELL_W     = 7;
  localparam int MARG_W     = 8;
  localparam int CHAR_W     = 8;
  localparam int POS_W      = 8;
  localparam int MODE_W     = 2;
  localparam int CMD_W      = 3;
  localparam int IDX_W      = 3;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;
  localparam int TAB_SPACES = 4;
  localparam int TAB_CNT_W  = 2;

  localparam logic [MODE_W-1:0] MODE_PUT    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SETCUR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [IDX_W-1:0] REG_SCREEN_W  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SCREEN_H  = 3'd1;
  localparam logic [IDX_W-1:0] REG_CELL_W    = 3'd2;
  localparam logic [IDX_W-1:0] REG_CELL_H    = 3'd3;
  localparam logic [IDX_W-1:0] REG_LEFT_MARG = 3'd4;
  localparam logic [IDX_W-1:0] REG_TOP_MARG  = 3'd5;

  localparam logic [SCR_W-1:0]  RST_SCREEN_W = 13'd1024;
  localparam logic [SCR_W-1:0]  RST_SCREEN_H = 13'd768;
  localparam logic [CELL_W-1:0] RST_CELL_W   = 7'd8;
  localparam logic [CELL_W-1:0] RST_CELL_H   = 7'd16;
  localparam logic [MARG_W-1:0] RST_LEFT     = 8'd2;
  localparam logic [MARG_W-1:0] RST_TOP      = 8'd2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_NEWLINE,
    OP_CR,
    OP_BS,
    OP_TAB,
    OP_GLYPH,
    OP_SETCUR,
    OP_CLEAR
  } op_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE         = 3'd0,
    CMD_GLYPH        = 3'd1,
    CMD_CLEAR_CELL   = 3'd2,
    CMD_SCROLL       = 3'd3,
    CMD_CLEAR_SCREEN = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAW,
    S_SET
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
  } qent_t;

  typedef struct packed {
    logic [SCR_W-1:0]  sw;
    logic [SCR_W-1:0]  sh;
    logic [CELL_W-1:0] cw;
    logic [CELL_W-1:0] ch;
    logic [MARG_W-1:0] lm;
    logic [MARG_W-1:0] tm;
  } cfg_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [CUR_W-1:0]  cell_x;
    logic [CUR_W-1:0]  cell_y;
    logic [CHAR_W-1:0] glyph;
    logic [CUR_W-1:0]  cur_x;
    logic [CUR_W-1:0]  cur_y;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/core/text_console_cursor_engine.sv -----
// Sequencing: the command sequencer takes a queued item in its idle state. Controls,
//   clear and unused modes emit from the run state; set-cursor multiplies in run and
//   emits from the set state; a printable byte, and each of a tab's four spaces, passes
//   run (emitting first if a wrap scrolls or clears), then its glyph from draw. The next
//   item waits for the previous one; at most one result per cycle, none under back-pressure.
// Reset: synchronous active-low rst_n restores register defaults, cursor to the margins
//   and empties the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none
module text_console_cursor_engine #(
  parameter int QUEUE_DEPTH = tcce_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [tcce_pkg::IN_DATA_W-1:0]    in_tdata,   // char_byte, text_row, text_col
  input  wire logic [tcce_pkg::MODE_W-1:0]       in_tuser,   // mode
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [tcce_pkg::OUT_DATA_W-1:0]        out_tdata,  // cell_x, cell_y, glyph,
                                                             // cursor_x, cursor_y
  output logic [tcce_pkg::CMD_W-1:0]             out_tuser,  // command
  output logic                                   out_tlast,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tcce_pkg::IDX_W-1:0]        cfg_index,
  input  wire logic [tcce_pkg::SCR_W-1:0]        cfg_data
);
  import tcce_pkg::*;

  cfg_t  cfg_r;
  logic  q_full, q_push, q_pop, q_valid;
  qent_t q_wr, q_rd;
  res_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sw <= RST_SCREEN_W;
      cfg_r.sh <= RST_SCREEN_H;
      cfg_r.cw <= RST_CELL_W;
      cfg_r.ch <= RST_CELL_H;
      cfg_r.lm <= RST_LEFT;
      cfg_r.tm <= RST_TOP;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_W:  cfg_r.sw <= cfg_data;
        REG_SCREEN_H:  cfg_r.sh <= cfg_data;
        REG_CELL_W:    cfg_r.cw <= cfg_data[CELL_W-1:0];
        REG_CELL_H:    cfg_r.ch <= cfg_data[CELL_W-1:0];
        REG_LEFT_MARG: cfg_r.lm <= cfg_data[MARG_W-1:0];
        REG_TOP_MARG:  cfg_r.tm <= cfg_data[MARG_W-1:0];
        default: ;
      endcase
    end
  end

  tcce_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_ent     (q_wr)
  );

  tcce_queue #(
    .WIDTH ($bits(qent_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wr),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rd),
    .valid (q_valid)
  );

  tcce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ent     (q_rd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tuser = res.cmd;
  assign out_tlast = res.last;
  assign out_tdata = {res.cur_y, res.cur_x, res.glyph, res.cell_y, res.cell_x};

  a_no_cell_for_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == CMD_NONE || out_tuser == CMD_CLEAR_SCREEN)
    |-> out_tdata[31:0] == 32'd0)
    else $error("command without a cell carries cell or glyph data");

  a_glyph_only_draw: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != CMD_GLYPH |-> out_tdata[31:24] == 8'd0)
    else $error("glyph code set on a non-draw command");

  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= CMD_CLEAR_SCREEN)
    else $error("command code out of range");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == CMD_SCROLL || out_tuser == CMD_CLEAR_SCREEN)
    |-> out_tdata[43:32] == 12'(cfg_r.lm))
    else $error("cursor not at left margin after scroll or clear");

endmodule
`default_nettype wire

// ----- rtl/core/tcce_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tcce_front (
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [tcce_pkg::MODE_W-1:0]      in_tuser,   // mode
  input  wire logic [tcce_pkg::IN_DATA_W-1:0]   in_tdata,   // char_byte, text_row, text_col
  input  wire logic                             q_full,
  output logic                                  q_push,
  output tcce_pkg::qent_t                       q_ent
);
  import tcce_pkg::*;

  logic [CHAR_W-1:0] ch;

  assign ch        = in_tdata[7:0];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_ent.ch  = ch;
    q_ent.row = in_tdata[15:8];
    q_ent.col = in_tdata[23:16];
    case (in_tuser)
      MODE_PUT: begin
        case (ch)
          CH_LF:   q_ent.op = OP_NEWLINE;
          CH_CR:   q_ent.op = OP_CR;
          CH_BS:   q_ent.op = OP_BS;
          CH_TAB:  q_ent.op = OP_TAB;
          default: q_ent.op = OP_GLYPH;
        endcase
      end
      MODE_SETCUR: q_ent.op = OP_SETCUR;
      MODE_CLEAR:  q_ent.op = OP_CLEAR;
      default:     q_ent.op = OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/tcce_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tcce_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  valid
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tcce_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tcce_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  tcce_pkg::cfg_t     cfg,
  input  wire logic          q_valid,
  input  tcce_pkg::qent_t    q_ent,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tcce_pkg::res_t     out_res
);
  import tcce_pkg::*;

  function automatic logic [CUR_W-1:0] sat12(input logic [15:0] v);
    return (v > 16'd4095) ? 12'hFFF : v[CUR_W-1:0];
  endfunction

  function automatic logic [CUR_W-1:0] clamp_pos(input logic [15:0] p,
                                                 input logic [SCR_W-1:0] size,
                                                 input logic [CELL_W-1:0] cell_sz);
    logic [CELL_W-1:0] step;
    logic [15:0]       q;
    step = (cell_sz == '0) ? CELL_W'(1) : cell_sz;
    q    = p;
    if (size != '0 && p >= 16'(size)) begin
      q = (size >= SCR_W'(step)) ? 16'(size - SCR_W'(step)) : 16'd0;
    end
    return sat12(q);
  endfunction

  back_state_t           state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [CHAR_W-1:0]     ch_r, ch_nxt;
  logic [POS_W-1:0]      in_row_r, in_row_nxt;
  logic [POS_W-1:0]      in_col_r, in_col_nxt;
  logic [TAB_CNT_W-1:0]  tab_r, tab_nxt;
  logic [14:0]           pc_r, pc_nxt;
  logic [14:0]           pr_r, pr_nxt;
  logic [CUR_W-1:0]      col_r, col_nxt;
  logic [CUR_W-1:0]      row_r, row_nxt;
  logic                  out_valid_r;
  res_t                  res_r;

  logic                  slot_free;
  logic                  emit;
  res_t                  e_res;
  logic                  draw_last;

  logic [CUR_W-1:0]      lm12, tm12;
  logic [13:0]           ny, ny2;
  logic                  ovf, full;
  logic [SCR_W-1:0]      shmc;
  logic [CUR_W-1:0]      shmc_sat;
  logic [CUR_W-1:0]      nl_row, nl_celly;
  cmd_t                  nl_cmd;
  logic [SCR_W-1:0]      colcw;
  logic                  wrap;
  logic [CUR_W-1:0]      adv;
  logic                  bs_home;
  logic [CUR_W-1:0]      bs_col, bs_row;
  logic [SCR_W-1:0]      swmc;
  logic [CUR_W-1:0]      set_col, set_row;

  assign lm12 = CUR_W'(cfg.lm);
  assign tm12 = CUR_W'(cfg.tm);

  // newline target
  always_comb begin
    ny       = 14'(row_r) + 14'(cfg.ch);
    ny2      = ny + 14'(cfg.ch);
    ovf      = ny2 > 14'(cfg.sh);
    full     = (cfg.ch == '0) || (SCR_W'(cfg.ch) >= cfg.sh);
    shmc     = cfg.sh - SCR_W'(cfg.ch);
    shmc_sat = sat12(16'(shmc));
    if (!ovf) begin
      nl_row = sat12(16'(ny));
      nl_cmd = CMD_NONE;
    end else begin
      nl_row = (cfg.sh >= SCR_W'(cfg.ch)) ? shmc_sat : '0;
      nl_cmd = full ? CMD_CLEAR_SCREEN : CMD_SCROLL;
    end
    nl_celly = (nl_cmd == CMD_SCROLL) ? shmc_sat : '0;
  end

  // glyph advance, backspace and set-cursor clamp
  always_comb begin
    colcw   = SCR_W'(col_r) + SCR_W'(cfg.cw);
    wrap    = colcw > cfg.sw;
    adv     = sat12(16'(colcw));
    bs_home = (row_r == tm12) && (col_r <= lm12);
    swmc    = cfg.sw - SCR_W'(cfg.cw);
    if (col_r >= CUR_W'(cfg.cw)) begin
      bs_col = col_r - CUR_W'(cfg.cw);
      bs_row = row_r;
    end else if (row_r >= CUR_W'(cfg.ch)) begin
      bs_row = row_r - CUR_W'(cfg.ch);
      bs_col = (cfg.sw >= SCR_W'(cfg.cw)) ? sat12(16'(swmc)) : '0;
    end else begin
      bs_col = '0;
      bs_row = '0;
    end
    set_col = clamp_pos(16'(cfg.lm) + 16'(pc_r), cfg.sw, cfg.cw);
    set_row = clamp_pos(16'(cfg.tm) + 16'(pr_r), cfg.sh, cfg.ch);
  end

  assign slot_free = !out_valid_r || out_ready;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign draw_last = (op_r != OP_TAB) || (tab_r == TAB_CNT_W'(TAB_SPACES - 1));

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    ch_nxt     = ch_r;
    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    tab_nxt    = tab_r;
    pc_nxt     = pc_r;
    pr_nxt     = pr_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    emit       = 1'b0;
    e_res      = '{cmd: CMD_NONE, cell_x: '0, cell_y: '0, glyph: '0,
                   cur_x: col_r, cur_y: row_r, last: 1'b1};
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          op_nxt     = q_ent.op;
          ch_nxt     = q_ent.ch;
          in_row_nxt = q_ent.row;
          in_col_nxt = q_ent.col;
          tab_nxt    = '0;
          state_nxt  = S_RUN;
        end
      end
      S_RUN: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
          case (op_r)
            OP_NEWLINE: begin
              col_nxt      = lm12;
              row_nxt      = nl_row;
              emit         = 1'b1;
              e_res.cmd    = nl_cmd;
              e_res.cell_y = nl_celly;
              e_res.cur_x  = lm12;
              e_res.cur_y  = nl_row;
            end
            OP_CR: begin
              col_nxt     = lm12;
              emit        = 1'b1;
              e_res.cur_x = lm12;
            end
            OP_BS: begin
              emit = 1'b1;
              if (!bs_home) begin
                col_nxt      = bs_col;
                row_nxt      = bs_row;
                e_res.cmd    = CMD_CLEAR_CELL;
                e_res.cell_x = bs_col;
                e_res.cell_y = bs_row;
                e_res.cur_x  = bs_col;
                e_res.cur_y  = bs_row;
              end
            end
            OP_GLYPH, OP_TAB: begin
              state_nxt = S_DRAW;
              if (wrap) begin
                col_nxt      = lm12;
                row_nxt      = nl_row;
                emit         = (nl_cmd != CMD_NONE);
                e_res.cmd    = nl_cmd;
                e_res.cell_y = nl_celly;
                e_res.cur_x  = lm12;
                e_res.cur_y  = nl_row;
                e_res.last   = 1'b0;
              end
            end
            OP_SETCUR: begin
              pc_nxt    = 15'(in_col_r) * 15'(cfg.cw);
              pr_nxt    = 15'(in_row_r) * 15'(cfg.ch);
              state_nxt = S_SET;
            end
            OP_CLEAR: begin
              col_nxt     = lm12;
              row_nxt     = tm12;
              emit        = 1'b1;
              e_res.cmd   = CMD_CLEAR_SCREEN;
              e_res.cur_x = lm12;
              e_res.cur_y = tm12;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_DRAW: begin
        if (slot_free) begin
          emit         = 1'b1;
          col_nxt      = adv;
          e_res.cmd    = CMD_GLYPH;
          e_res.cell_x = col_r;
          e_res.cell_y = row_r;
          e_res.glyph  = (op_r == OP_TAB) ? CH_SPACE : ch_r;
          e_res.cur_x  = adv;
          e_res.last   = draw_last;
          if (draw_last) begin
            state_nxt = S_IDLE;
          end else begin
            tab_nxt   = tab_r + 1'b1;
            state_nxt = S_RUN;
          end
        end
      end
      S_SET: begin
        if (slot_free) begin
          col_nxt     = set_col;
          row_nxt     = set_row;
          emit        = 1'b1;
          e_res.cur_x = set_col;
          e_res.cur_y = set_row;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= CUR_W'(RST_LEFT);
      row_r       <= CUR_W'(RST_TOP);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    ch_r     <= ch_nxt;
    in_row_r <= in_row_nxt;
    in_col_r <= in_col_nxt;
    tab_r    <= tab_nxt;
    pc_r     <= pc_nxt;
    pr_r     <= pr_nxt;
    if (emit) begin
      res_r <= e_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire
